### src/dcf_pkg.sv
// Shared types and codes for the contention access engine.
`default_nettype none
package dcf_pkg;

  // Access state codes as reported on the result word
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DEFER    = 3'd1;
  localparam logic [2:0] ST_BACKOFF  = 3'd2;
  localparam logic [2:0] ST_TRANSMIT = 3'd3;
  localparam logic [2:0] ST_WAIT_IFS = 3'd4;

  // Request kinds carried in in_tuser
  localparam logic [2:0] REQ_START    = 3'd0;
  localparam logic [2:0] REQ_MEDIUM   = 3'd1;
  localparam logic [2:0] REQ_TICK     = 3'd2;
  localparam logic [2:0] REQ_TX_DONE  = 3'd3;
  localparam logic [2:0] REQ_RX_FRAME = 3'd4;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [15:0] rand_value;
    logic [3:0]  retry_count;
    logic [9:0]  cw_max;
    logic [9:0]  cw_min;
    logic [13:0] eifs_ticks;
    logic [11:0] ifs_ticks;
    logic        fcs_ok;
    logic        medium_free;
    logic [2:0]  req_type;
  } dcf_item_t;

  typedef struct packed {
    logic       eifs_armed;
    logic [9:0] backoff_left;
    logic       tx_complete;
    logic       send_frame;
    logic [2:0] access_state;
  } dcf_result_t;

endpackage
`default_nettype wire

### src/dcf_backoff_draw.sv
// Contention window and backoff slot draw for a start word.
`default_nettype none
module dcf_backoff_draw import dcf_pkg::*; #(
  parameter int CW_BITS = 10
) (
  input  wire logic [9:0]         cw_min,
  input  wire logic [9:0]         cw_max,
  input  wire logic [3:0]         retry_count,
  input  wire logic [15:0]        rand_value,
  output logic      [CW_BITS-1:0] slots
);

  logic [25:0]        cw_full;
  logic [CW_BITS-1:0] cap_masked;
  logic [25:0]        cap;
  logic [25:0]        cw_sel;
  logic [10:0]        cw_p1;
  logic [26:0]        prod;

  always_comb begin
    cw_full    = (26'({1'b0, cw_min} + 11'd1) << retry_count) - 26'd1;
    cap_masked = CW_BITS'(cw_max);
    cap        = 26'(cap_masked);
    cw_sel     = (cw_full > cap) ? cap : cw_full;
    // cw_sel never exceeds 1023, so the window size fits 11 bits
    cw_p1      = 11'(cw_sel) + 11'd1;
    prod       = 27'(rand_value) * 27'(cw_p1);
    slots      = CW_BITS'(prod >> 16);
  end

endmodule
`default_nettype wire

### src/dcf_access_core.sv
// Access state machine: state registers and next-state logic per word.
`default_nettype none
module dcf_access_core import dcf_pkg::*; #(
  parameter int CW_BITS   = 10,
  parameter int TICK_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_go,
  input  wire dcf_item_t   item,
  input  wire logic [9:0]  slot_ticks,
  output dcf_result_t      result
);

  localparam int CMP_W = (TICK_BITS > 14) ? TICK_BITS : 14;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  logic [2:0]           state_r, state_nxt;
  logic                 med_free_r, med_free_nxt;
  logic                 use_eifs_r, use_eifs_nxt;
  logic                 eifs_wait_r, eifs_wait_nxt;
  logic [TICK_BITS-1:0] free_ticks_r, free_ticks_nxt;
  logic [CW_BITS-1:0]   slots_r, slots_nxt;
  logic [9:0]           phase_r, phase_nxt;
  logic [11:0]          ifs_r, ifs_nxt;
  logic [13:0]          eifs_r, eifs_nxt;

  logic [CW_BITS-1:0]   draw_slots;
  logic                 sent, done;
  logic [TICK_BITS-1:0] ft_inc;
  logic [CMP_W-1:0]     ft_cmp;
  logic                 ft_sat;
  logic                 ifs_reached, eifs_reached;
  logic                 st_ifs_reached, st_eifs_reached;
  logic                 eifs_now_reached;

  dcf_backoff_draw #(.CW_BITS(CW_BITS)) u_draw (
    .cw_min      (item.cw_min),
    .cw_max      (item.cw_max),
    .retry_count (item.retry_count),
    .rand_value  (item.rand_value),
    .slots       (draw_slots)
  );

  always_comb begin
    ft_inc = (free_ticks_r == TICK_MAX) ? free_ticks_r : free_ticks_r + 1'b1;
    ft_cmp = CMP_W'(ft_inc);
    ft_sat = (ft_inc == TICK_MAX);
    // free time against saved thresholds after this tick; a threshold above
    // the counter range counts as reached once the counter saturates
    ifs_reached  = (ft_cmp >= CMP_W'(ifs_r)) || ft_sat;
    eifs_reached = (ft_cmp >= CMP_W'(eifs_r)) || ft_sat;
    // free time as it stands against the thresholds of a start word
    st_ifs_reached  = (CMP_W'(free_ticks_r) >= CMP_W'(item.ifs_ticks))
                      || (free_ticks_r == TICK_MAX);
    st_eifs_reached = (CMP_W'(free_ticks_r) >= CMP_W'(item.eifs_ticks))
                      || (free_ticks_r == TICK_MAX);
    // saved EIFS against a restarted (zero) counter
    eifs_now_reached = (eifs_r == 14'd0) || (TICK_MAX == '0);
  end

  always_comb begin
    state_nxt      = state_r;
    med_free_nxt   = med_free_r;
    use_eifs_nxt   = use_eifs_r;
    eifs_wait_nxt  = eifs_wait_r;
    free_ticks_nxt = free_ticks_r;
    slots_nxt      = slots_r;
    phase_nxt      = phase_r;
    ifs_nxt        = ifs_r;
    eifs_nxt       = eifs_r;
    sent           = 1'b0;
    done           = 1'b0;
    case (item.req_type)
      REQ_START: begin
        if (state_r == ST_IDLE) begin
          ifs_nxt   = item.ifs_ticks;
          eifs_nxt  = item.eifs_ticks;
          slots_nxt = draw_slots;
          phase_nxt = '0;
          if (!med_free_r) begin
            state_nxt = ST_DEFER;
          end else if (!st_ifs_reached || (use_eifs_r && !st_eifs_reached)) begin
            state_nxt     = ST_WAIT_IFS;
            eifs_wait_nxt = use_eifs_r && !st_eifs_reached;
            use_eifs_nxt  = 1'b0;
          end else begin
            state_nxt = ST_TRANSMIT;
            sent      = 1'b1;
          end
        end
      end
      REQ_MEDIUM: begin
        med_free_nxt   = item.medium_free;
        free_ticks_nxt = '0;
        if (state_r == ST_DEFER && item.medium_free) begin
          state_nxt     = ST_WAIT_IFS;
          eifs_wait_nxt = use_eifs_r && !eifs_now_reached;
          use_eifs_nxt  = 1'b0;
        end else if (state_r == ST_WAIT_IFS && !item.medium_free) begin
          eifs_wait_nxt = 1'b0;
          state_nxt     = ST_DEFER;
        end else if (state_r == ST_BACKOFF && !item.medium_free) begin
          phase_nxt = '0;
          state_nxt = ST_DEFER;
        end
      end
      REQ_TICK: begin
        free_ticks_nxt = ft_inc;
        if (state_r == ST_WAIT_IFS) begin
          if (ifs_reached && (!eifs_wait_r || eifs_reached)) begin
            eifs_wait_nxt = 1'b0;
            phase_nxt     = '0;
            if (slots_r == '0) begin
              state_nxt = ST_TRANSMIT;
              sent      = 1'b1;
            end else begin
              state_nxt = ST_BACKOFF;
            end
          end
        end else if (state_r == ST_BACKOFF) begin
          if (slots_r == '0) begin
            state_nxt = ST_TRANSMIT;
            sent      = 1'b1;
          end else if (({1'b0, phase_r} + 11'd1) >= {1'b0, slot_ticks}) begin
            // slot elapsed: count it off
            phase_nxt = '0;
            slots_nxt = slots_r - 1'b1;
            if (slots_r == CW_BITS'(1)) begin
              state_nxt = ST_TRANSMIT;
              sent      = 1'b1;
            end
          end else begin
            phase_nxt = phase_r + 10'd1;
          end
        end
      end
      REQ_TX_DONE: begin
        if (state_r == ST_TRANSMIT) begin
          state_nxt = ST_IDLE;
          done      = 1'b1;
        end
      end
      REQ_RX_FRAME: begin
        use_eifs_nxt = !item.fcs_ok;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.access_state = state_nxt;
    result.send_frame   = sent;
    result.tx_complete  = done;
    result.backoff_left = 10'(slots_nxt);
    result.eifs_armed   = use_eifs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      med_free_r   <= 1'b0;
      use_eifs_r   <= 1'b0;
      eifs_wait_r  <= 1'b0;
      free_ticks_r <= '0;
      slots_r      <= '0;
      phase_r      <= '0;
      ifs_r        <= '0;
      eifs_r       <= '0;
    end else if (item_go) begin
      state_r      <= state_nxt;
      med_free_r   <= med_free_nxt;
      use_eifs_r   <= use_eifs_nxt;
      eifs_wait_r  <= eifs_wait_nxt;
      free_ticks_r <= free_ticks_nxt;
      slots_r      <= slots_nxt;
      phase_r      <= phase_nxt;
      ifs_r        <= ifs_nxt;
      eifs_r       <= eifs_nxt;
    end
  end

endmodule
`default_nettype wire

### src/dcf_contention_access_fsm_top.sv
// Top level of the contention access engine: word registers and config.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in_     | slave     | in_tvalid / in_tready      | in_tuser, in_tdata (72 b)
//   out_    | master    | out_tvalid / out_tready    | out_tdata (16 b)
//   cfg_    | slave     | cfg_valid / cfg_ready      | cfg_data = slot_ticks
//
// A word taken into the input register is processed in one pass; its status
// word enters the result register when that is empty or being read. One word
// per cycle is accepted unless out_tready stalls: a stalled out_tready holds
// the result register, the input register takes one more word, then in_tready
// drops until the result moves. Synchronous reset (rst_n low) idles the engine,
// clears all counters and sets slot_ticks to 9; cfg_ready is always high.
`default_nettype none
module dcf_contention_access_fsm_top import dcf_pkg::*; #(
  parameter int CW_BITS   = 10,
  parameter int TICK_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tuser: req_type[2:0]
  input  wire logic [2:0]            in_tuser,
  // in_tdata: medium_free[0], fcs_ok[1], ifs_ticks[13:2], eifs_ticks[27:14],
  //   cw_min[37:28], cw_max[47:38], retry_count[51:48], rand_value[67:52],
  //   zero fill [71:68]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: access_state[2:0], send_frame[3], tx_complete[4],
  //   backoff_left[14:5], eifs_armed[15]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [9:0]            cfg_data
);

  dcf_item_t   item_r;
  logic        item_vld_r;
  dcf_result_t res_r;
  logic        res_vld_r;
  logic [9:0]  slot_ticks_r;
  dcf_result_t res_comb;
  logic        advance;
  logic        in_go;

  // Move the held word into the result register when that slot frees up
  assign advance   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || !res_vld_r || out_tready;
  assign in_go     = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_ticks_r <= 10'd9;
    end else if (cfg_valid) begin
      slot_ticks_r <= cfg_data;
    end
  end

  // Input register: hold the word until the access logic consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_go) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      item_r.req_type    <= in_tuser;
      item_r.medium_free <= in_tdata[0];
      item_r.fcs_ok      <= in_tdata[1];
      item_r.ifs_ticks   <= in_tdata[13:2];
      item_r.eifs_ticks  <= in_tdata[27:14];
      item_r.cw_min      <= in_tdata[37:28];
      item_r.cw_max      <= in_tdata[47:38];
      item_r.retry_count <= in_tdata[51:48];
      item_r.rand_value  <= in_tdata[67:52];
    end
  end

  dcf_access_core #(
    .CW_BITS   (CW_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (advance),
    .item       (item_r),
    .slot_ticks (slot_ticks_r),
    .result     (res_comb)
  );

  // Result register: hold the word while out_tready is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {res_r.eifs_armed, res_r.backoff_left, res_r.tx_complete,
                       res_r.send_frame, res_r.access_state};

endmodule
`default_nettype wire

### bench/dcf_contention_access_fsm_top_tb.sv
// Self-checking testbench for the contention access engine top level.
`timescale 1ns / 1ps
module dcf_contention_access_fsm_top_tb;
  import dcf_pkg::*;

  // Request kinds that the engine does not know; they only report the state
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam logic [13:0] IDLE_TICKS_SAT = 14'h3FFF;
  localparam int MAX_REPORTED = 10;

  // Predictor state: one copy tracks accepted words, a second one steers the
  // stimulus generator so it can build sequences that reach transmit.
  typedef struct packed {
    logic [2:0]  fsm;
    logic        medium_free;
    logic        eifs_armed;
    logic        eifs_wait;
    logic [13:0] idle_ticks;
    logic [9:0]  slots_left;
    logic [9:0]  slot_phase;
    logic [9:0]  slot_len;
    logic [11:0] ifs_len;
    logic [13:0] eifs_len;
  } engine_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2:0]            in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [9:0]            cfg_data = '0;

  engine_t     live_eng;
  engine_t     plan_eng;
  dcf_item_t   pending_words[$];
  dcf_result_t expected_status[$];
  dcf_item_t   cur_word = '0;
  int          planned_words = 0;
  int          mismatches = 0;

  // Sender pacing
  int          gap_left = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  // Receiver pacing and the one long hold-off
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          pace_left = 0;
  int          pace_mode = 0;
  logic [1:0]  beat = '0;

  dcf_contention_access_fsm_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed upper bound on the run; a hang ends here.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic engine_t engine_reset();
    engine_t s;
    s = '0;
    s.fsm = ST_IDLE;
    s.slot_len = 10'd9;
    return s;
  endfunction

  // Start waiting for the interframe space; arm the EIFS wait only if the
  // bad-FCS flag is up and the extended space has not yet gone by.
  function automatic void enter_ifs_wait(inout engine_t s);
    s.fsm = ST_WAIT_IFS;
    s.eifs_wait = s.eifs_armed && (s.eifs_len > s.idle_ticks);
    s.eifs_armed = 1'b0;
  endfunction

  // Advance the access engine by one word and return the status it reports.
  function automatic dcf_result_t engine_step(inout engine_t s, input dcf_item_t w);
    dcf_result_t r;
    int unsigned cw;
    logic        sent;
    logic        done;
    sent = 1'b0;
    done = 1'b0;
    case (w.req_type)
      REQ_START: begin
        if (s.fsm == ST_IDLE) begin
          cw = ((32'(w.cw_min) + 32'd1) << w.retry_count) - 32'd1;
          if (cw > 32'(w.cw_max)) cw = 32'(w.cw_max);
          s.ifs_len = w.ifs_ticks;
          s.eifs_len = w.eifs_ticks;
          s.slots_left = 10'((32'(w.rand_value) * (cw + 32'd1)) >> 16);
          s.slot_phase = '0;
          if (!s.medium_free) begin
            s.fsm = ST_DEFER;
          end else if (s.idle_ticks < 14'(s.ifs_len) ||
                       (s.eifs_armed && s.idle_ticks < s.eifs_len)) begin
            enter_ifs_wait(s);
          end else begin
            s.fsm = ST_TRANSMIT;
            sent = 1'b1;
          end
        end
      end
      REQ_MEDIUM: begin
        s.medium_free = w.medium_free;
        s.idle_ticks = '0;
        if (s.fsm == ST_DEFER && w.medium_free) begin
          enter_ifs_wait(s);
        end else if (s.fsm == ST_WAIT_IFS && !w.medium_free) begin
          s.eifs_wait = 1'b0;
          s.fsm = ST_DEFER;
        end else if (s.fsm == ST_BACKOFF && !w.medium_free) begin
          // drop the partial slot, keep the whole ones already counted
          s.slot_phase = '0;
          s.fsm = ST_DEFER;
        end
      end
      REQ_TICK: begin
        if (s.idle_ticks != IDLE_TICKS_SAT) s.idle_ticks = s.idle_ticks + 14'd1;
        if (s.fsm == ST_WAIT_IFS) begin
          if (s.idle_ticks >= 14'(s.ifs_len) &&
              (!s.eifs_wait || s.idle_ticks >= s.eifs_len)) begin
            s.eifs_wait = 1'b0;
            s.slot_phase = '0;
            if (s.slots_left == '0) begin
              s.fsm = ST_TRANSMIT;
              sent = 1'b1;
            end else begin
              s.fsm = ST_BACKOFF;
            end
          end
        end else if (s.fsm == ST_BACKOFF) begin
          if (s.slots_left == '0) begin
            s.fsm = ST_TRANSMIT;
            sent = 1'b1;
          end else if (32'(s.slot_phase) + 32'd1 >= 32'(s.slot_len)) begin
            // a zero slot length counts as one tick per slot
            s.slot_phase = '0;
            s.slots_left = s.slots_left - 10'd1;
            if (s.slots_left == '0) begin
              s.fsm = ST_TRANSMIT;
              sent = 1'b1;
            end
          end else begin
            s.slot_phase = s.slot_phase + 10'd1;
          end
        end
      end
      REQ_TX_DONE: begin
        if (s.fsm == ST_TRANSMIT) begin
          s.fsm = ST_IDLE;
          done = 1'b1;
        end
      end
      REQ_RX_FRAME: begin
        s.eifs_armed = !w.fcs_ok;
      end
      default: ;
    endcase
    r.access_state = s.fsm;
    r.send_frame = sent;
    r.tx_complete = done;
    r.backoff_left = s.slots_left;
    r.eifs_armed = s.eifs_armed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Queue a word and advance the planning copy so later choices see its effect.
  task automatic schedule_word(input dcf_item_t w);
    void'(engine_step(plan_eng, w));
    pending_words.push_back(w);
    planned_words++;
  endtask

  // Fill every field at random; the engine ignores the ones a kind does not use.
  function automatic dcf_item_t noise_word(input logic [2:0] req);
    dcf_item_t w;
    w.req_type = req;
    w.medium_free = 1'($urandom_range(0, 1));
    w.fcs_ok = 1'($urandom_range(0, 1));
    w.ifs_ticks = 12'($urandom_range(0, 4095));
    w.eifs_ticks = 14'($urandom_range(0, 16383));
    w.cw_min = 10'($urandom_range(0, 1023));
    w.cw_max = 10'($urandom_range(0, 1023));
    w.retry_count = 4'($urandom_range(0, 15));
    w.rand_value = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  // flag lands on both medium_free and fcs_ok; the kind decides which counts
  task automatic push_ctl(input logic [2:0] req, input logic flag);
    dcf_item_t w;
    w = noise_word(req);
    w.medium_free = flag;
    w.fcs_ok = flag;
    schedule_word(w);
  endtask

  task automatic push_start(input int ifs, input int eifs, input int cwmin,
                            input int cwmax, input int retry, input int rnd);
    dcf_item_t w;
    w = noise_word(REQ_START);
    w.ifs_ticks = 12'(ifs);
    w.eifs_ticks = 14'(eifs);
    w.cw_min = 10'(cwmin);
    w.cw_max = 10'(cwmax);
    w.retry_count = 4'(retry);
    w.rand_value = 16'(rnd);
    schedule_word(w);
  endtask

  // Short spaces and a draw bounded so that the backoff stays within about a dozen slots;
  // the window limits themselves still span their whole range.
  task automatic random_start();
    int unsigned cwmin;
    int unsigned cwmax;
    int unsigned retry;
    int unsigned cw;
    int unsigned lim;
    cwmin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
    cwmax = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
    retry = $urandom_range(0, 15);
    cw = ((cwmin + 1) << retry) - 1;
    if (cw > cwmax) cw = cwmax;
    lim = (12 * 65536) / (cw + 1);
    if (lim > 65535) lim = 65535;
    push_start($urandom_range(0, 10), $urandom_range(0, 24), cwmin, cwmax, retry,
               $urandom_range(0, lim));
  endtask

  // Walk the planned engine back to idle: free the medium, tick, finish the frame.
  task automatic bring_home();
    while (plan_eng.fsm != ST_IDLE) begin
      case (plan_eng.fsm)
        ST_TRANSMIT: push_ctl(REQ_TX_DONE, 1'($urandom_range(0, 1)));
        ST_DEFER:    push_ctl(REQ_MEDIUM, 1'b1);
        default:     push_ctl(REQ_TICK, 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // One access attempt: start, then mostly ticks with medium changes and noise
  // mixed in, until the frame goes out; then report the transmission finished.
  task automatic access_attempt();
    int  step;
    int  pick;
    logic free;
    if ($urandom_range(0, 3) == 0) push_ctl(REQ_RX_FRAME, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) push_ctl(REQ_MEDIUM, $urandom_range(0, 3) != 0);
    random_start();
    for (step = 0; step < 60 && plan_eng.fsm != ST_TRANSMIT; step++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        push_ctl(REQ_TICK, 1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
        free = (plan_eng.fsm == ST_DEFER) ? ($urandom_range(0, 6) != 0)
                                         : ($urandom_range(0, 2) != 0);
        push_ctl(REQ_MEDIUM, free);
      end else if (pick < 91) begin
        push_ctl(REQ_RX_FRAME, 1'($urandom_range(0, 1)));
      end else if (pick < 94) begin
        push_ctl(3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST)),
                 1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
        schedule_word(noise_word(REQ_START));
      end else begin
        push_ctl(REQ_TX_DONE, 1'($urandom_range(0, 1)));
      end
    end
    if (plan_eng.fsm == ST_TRANSMIT) begin
      if ($urandom_range(0, 1) == 0) push_ctl(REQ_TICK, 1'($urandom_range(0, 1)));
      push_ctl(REQ_TX_DONE, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int n_words);
    int target;
    bring_home();
    target = planned_words + n_words;
    while (planned_words < target) access_attempt();
  endtask

  // Wait until every word is in and every status word is out, then let the
  // input and result registers run dry.
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_len(input logic [9:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_eng.slot_len = v;
    plan_eng.slot_len = v;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    live_eng = engine_reset();
    plan_eng = engine_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset slot length: idle noise, EIFS arm and
    // disarm, a start under a busy medium, an ignored start with every field
    // at its top, a redundant free report, the empty window, immediate
    // transmit, EIFS wait dropped by a busy medium, busy during backoff.
    push_ctl(REQ_TICK, 1'b0);
    push_ctl(REQ_UNKNOWN_LAST, 1'b1);
    push_ctl(REQ_TX_DONE, 1'b1);
    push_ctl(REQ_RX_FRAME, 1'b0);
    push_ctl(REQ_RX_FRAME, 1'b1);
    push_start(2, 3, 0, 0, 0, 65535);
    push_start(4095, 16383, 1023, 1023, 15, 65535);
    push_ctl(REQ_MEDIUM, 1'b1);
    push_ctl(REQ_MEDIUM, 1'b1);
    push_ctl(REQ_TICK, 1'b0);
    push_ctl(REQ_TICK, 1'b1);
    push_ctl(REQ_TX_DONE, 1'b0);
    push_start(1, 0, 1023, 1023, 15, 0);
    push_ctl(REQ_TX_DONE, 1'b1);
    push_ctl(REQ_RX_FRAME, 1'b0);
    push_ctl(REQ_MEDIUM, 1'b0);
    push_ctl(REQ_MEDIUM, 1'b1);
    push_start(0, 2, 3, 1, 2, 40000);
    push_ctl(REQ_TICK, 1'b0);
    push_ctl(REQ_MEDIUM, 1'b0);
    push_ctl(REQ_MEDIUM, 1'b1);
    push_ctl(REQ_TICK, 1'b1);
    push_ctl(REQ_MEDIUM, 1'b0);
    push_ctl(REQ_MEDIUM, 1'b1);
    push_ctl(REQ_TICK, 1'b0);
    run_phase(130);
    drain();

    // Zero slot length, with the widest window and the top draw: count all
    // 1023 slots down, with a busy stretch in the middle.
    write_slot_len(10'd0);
    bring_home();
    push_start(0, 0, 1023, 1023, 15, 65535);
    if (!plan_eng.medium_free) push_ctl(REQ_MEDIUM, 1'b1);
    for (k = 0; k < 1100 && plan_eng.fsm != ST_TRANSMIT; k++) begin
      if (k == 500) begin
        push_ctl(REQ_MEDIUM, 1'b0);
        push_ctl(REQ_MEDIUM, 1'b1);
      end
      push_ctl(REQ_TICK, 1'($urandom_range(0, 1)));
    end
    run_phase(120);
    drain();

    // Hold the result side off for a long stretch while words keep coming.
    write_slot_len(10'd1);
    hold_req = 1'b1;
    run_phase(180);
    drain();

    write_slot_len(10'd1023);
    run_phase(60);
    drain();

    // Back-to-back words, no stalls on either side.
    write_slot_len(10'd2);
    steady = 1'b1;
    run_phase(160);
    drain();
    steady = 1'b0;

    write_slot_len(10'd3);
    run_phase(160);
    drain();

    write_slot_len(10'($urandom_range(4, 12)));
    run_phase(140);
    drain();
    repeat (10) @(posedge clk);

    if (expected_status.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d status words never arrived", expected_status.size());
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer words in bursts, hold a word until it is taken, predict its
  // status at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_status.push_back(engine_step(live_eng, cur_word));
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = (steady || $urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
        end
      end
      in_tvalid <= nxt_valid;
      in_tuser <= cur_word.req_type;
      in_tdata <= {4'b0000, cur_word[70:3]};
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing: switch between always ready, mostly ready, mostly stalled
  // and a fixed three-of-four pattern; one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_pace
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else begin
      beat <= beat + 2'd1;
      if (pace_left == 0) begin
        pace_mode <= $urandom_range(0, 3);
        pace_left <= $urandom_range(16, 96);
      end else begin
        pace_left <= pace_left - 1;
      end
      if (steady) begin
        out_tready <= 1'b1;
      end else begin
        case (pace_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (beat != 2'b11);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each status word taken with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : status_check
    dcf_result_t got;
    dcf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("ERROR: unexpected status word %h", got);
      end else begin
        want = expected_status.pop_front();
        if (got.access_state !== want.access_state || got.send_frame !== want.send_frame ||
            got.tx_complete !== want.tx_complete || got.backoff_left !== want.backoff_left ||
            got.eifs_armed !== want.eifs_armed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display({"ERROR at %0t: state %0d/%0d send %0d/%0d done %0d/%0d ",
                      "left %0d/%0d eifs %0d/%0d (exp/act)"},
                     $realtime, want.access_state, got.access_state,
                     want.send_frame, got.send_frame, want.tx_complete, got.tx_complete,
                     want.backoff_left, got.backoff_left, want.eifs_armed, got.eifs_armed);
        end
      end
    end
  end

endmodule
